### hw/rtl/arcpr_pkg.sv
// ----------------------------------------------------------------------------
// arcpr_pkg
// shared types and constants of the arc page replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package arcpr_pkg;

	localparam int MAX_PAGES_DEF = 4096;
	localparam int PAGE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 8;

	localparam int CAP_W   = 13;
	localparam int PAGE_W  = 32;
	localparam int BAL_W   = 21;
	localparam int CNT_W   = 32;
	localparam int CODE_W  = 3;

	// list selector: recent, frequent, recent ghosts, frequent ghosts
	typedef enum logic [1:0] {
		LST_T1,
		LST_T2,
		LST_B1,
		LST_B2
	} lst_t;

	localparam logic [CODE_W-1:0] CODE_HIT_T1 = 3'd0;
	localparam logic [CODE_W-1:0] CODE_HIT_T2 = 3'd1;
	localparam logic [CODE_W-1:0] CODE_GHOST_B1 = 3'd2;
	localparam logic [CODE_W-1:0] CODE_GHOST_B2 = 3'd3;
	localparam logic [CODE_W-1:0] CODE_MISS = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/arcpr_ram.sv
// ----------------------------------------------------------------------------
// arcpr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module arcpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

### hw/rtl/arcpr_div.sv
// ----------------------------------------------------------------------------
// arcpr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module arcpr_div #(
	parameter int NW = 21,
	parameter int DW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic      [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;

	assign sh   = {rem_q, quo_q[NW-1]};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (sh >= {1'b0, dvs_q}) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### hw/rtl/arc_page_replacement.sv
// ----------------------------------------------------------------------------
// arc_page_replacement
// adaptive replacement cache policy over four lru ordered page lists
// ----------------------------------------------------------------------------
// One page number enters per access and one result leaves. The four lists
// live in four rams, head at entry 0; a sequencer searches them one entry a
// cycle and closes the gap after a removal by moving one entry a cycle. A
// frequent ghost hit on full lists is the longest path, with up to ten sweeps
// and one divide. The ghost hit divide is a bit serial unit. A new access is
// taken once the previous result sits in the output register.
`default_nettype none

module arc_page_replacement
	import arcpr_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CAP_W-1:0]  cfg_wr_data,  // capacity
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [PAGE_W-1:0] s_tdata,      // page
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [87:0]            m_tdata,      // balance_now, hits_so_far, misses_so_far
	output logic [3:0]             m_tuser       // hit, case_code
);

	localparam int LW = $clog2(MAX_PAGES + 1);
	localparam int AW = $clog2(MAX_PAGES);
	localparam int PW = LW + FRAC_BITS;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FIND, ST_RM, ST_HD0, ST_HD1, ST_RPX, ST_AP, ST_AW,
		ST_M1, ST_M1B, ST_M2, ST_M3, ST_M4, ST_MISS, ST_DIVS, ST_DIVW,
		ST_REPL, ST_RP1, ST_POST, ST_PM, ST_PA, ST_DONE
	} state_t;

	state_t                state_q, ret_q, ret2_q;
	lst_t                  lst_q;
	logic [LW-1:0]         len_q [4];
	logic [LW-1:0]         cap_q;
	logic [LW-1:0]         ptr_q, at_q, fat_q, adr_s1;
	logic                  vld_s1, found_q;
	logic [PAGE_BITS-1:0]  x_q, val_q;
	logic [PW-1:0]         bal_q;
	logic [CNT_W-1:0]      hits_q, misses_q;
	logic [CODE_W-1:0]     code_q;

	logic                  m_tvalid_q;
	logic [87:0]           m_tdata_q;
	logic [3:0]            m_tuser_q;

	logic [PAGE_BITS-1:0]  rd_all [4];
	logic [PAGE_BITS-1:0]  rd_data;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [PAGE_BITS-1:0]  wr_data;
	logic [LW-1:0]         cur_len;
	logic                  match;

	logic                  div_start, div_done;
	logic [PW-1:0]         div_num, div_q;
	logic [LW-1:0]         div_den;

	logic [PW-1:0]         one_fx, lim_fx, delta, t1_fx;
	logic [PW:0]           bal_sum;
	logic [LW:0]           l1;
	logic [LW+1:0]         all_len;
	logic [LW-1:0]         cap_new;

	assign cur_len = len_q[lst_q];
	assign rd_data = rd_all[lst_q];
	assign match   = vld_s1 && (rd_data == x_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = adr_s1[AW-1:0] - 1'b1;
		wr_data = rd_data;
		if (state_q == ST_RM && vld_s1) begin
			wr_en = 1'b1;
		end else if (state_q == ST_AW && cur_len < LW'(MAX_PAGES)) begin
			wr_en   = 1'b1;
			wr_addr = cur_len[AW-1:0];
			wr_data = val_q;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_list
		arcpr_ram #(
			.WIDTH(PAGE_BITS),
			.DEPTH(MAX_PAGES)
		) u_ram (
			.clk    (clk),
			.wr_en  (wr_en && (lst_q == lst_t'(g))),
			.wr_addr(wr_addr),
			.wr_data(wr_data),
			.rd_addr(ptr_q[AW-1:0]),
			.rd_data(rd_all[g])
		);
	end

	assign div_start = (state_q == ST_DIVS);
	assign div_num   = (code_q == CODE_GHOST_B1) ? (PW'(len_q[LST_B2]) << FRAC_BITS)
	                                             : (PW'(len_q[LST_B1]) << FRAC_BITS);
	assign div_den   = (code_q == CODE_GHOST_B1) ? len_q[LST_B1] : len_q[LST_B2];

	arcpr_div #(
		.NW(PW),
		.DW(LW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_q)
	);

	assign one_fx  = PW'(1) << FRAC_BITS;
	assign lim_fx  = PW'(cap_q) << FRAC_BITS;
	assign delta   = (div_q < one_fx) ? one_fx : div_q;
	assign bal_sum = {1'b0, bal_q} + {1'b0, delta};
	assign t1_fx   = PW'(len_q[LST_T1]) << FRAC_BITS;
	assign l1      = {1'b0, len_q[LST_T1]} + {1'b0, len_q[LST_B1]};
	assign all_len = {1'b0, l1} + (LW+2)'(len_q[LST_T2]) + (LW+2)'(len_q[LST_B2]);

	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_new = LW'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_PAGES)) begin
			cap_new = LW'(MAX_PAGES);
		end else begin
			cap_new = LW'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			ret2_q     <= ST_IDLE;
			lst_q      <= LST_T1;
			for (int i = 0; i < 4; i++) begin
				len_q[i] <= '0;
			end
			cap_q      <= (MAX_PAGES > 4096) ? LW'(4096) : LW'(MAX_PAGES);
			bal_q      <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cap_new;
			end
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q     <= PAGE_BITS'(s_tdata);
						lst_q   <= LST_T1;
						ptr_q   <= '0;
						vld_s1  <= 1'b0;
						ret_q   <= ST_M1;
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (match) begin
						found_q <= 1'b1;
						fat_q   <= adr_s1;
						vld_s1  <= 1'b0;
						state_q <= ret_q;
					end else if (ptr_q < cur_len) begin
						vld_s1 <= 1'b1;
						adr_s1 <= ptr_q;
						ptr_q  <= ptr_q + 1'b1;
					end else begin
						found_q <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= ret_q;
					end
				end
				ST_RM: begin
					if (ptr_q < cur_len) begin
						vld_s1 <= 1'b1;
						adr_s1 <= ptr_q;
						ptr_q  <= ptr_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							if (at_q < cur_len) begin
								len_q[lst_q] <= cur_len - 1'b1;
							end
							state_q <= ret_q;
						end
					end
				end
				ST_HD0: begin
					state_q <= ST_HD1;
				end
				ST_HD1: begin
					val_q   <= rd_data;
					at_q    <= '0;
					ptr_q   <= LW'(1);
					vld_s1  <= 1'b0;
					ret_q   <= ST_RPX;
					state_q <= ST_RM;
				end
				ST_RPX: begin
					lst_q   <= (lst_q == LST_T1) ? LST_B1 : LST_B2;
					ret_q   <= ST_POST;
					state_q <= ST_AP;
				end
				ST_AP: begin
					ret2_q <= ret_q;
					if (cur_len >= cap_q || cur_len >= LW'(MAX_PAGES)) begin
						at_q    <= '0;
						ptr_q   <= LW'(1);
						vld_s1  <= 1'b0;
						ret_q   <= ST_AW;
						state_q <= ST_RM;
					end else begin
						state_q <= ST_AW;
					end
				end
				ST_AW: begin
					if (cur_len < LW'(MAX_PAGES)) begin
						len_q[lst_q] <= cur_len + 1'b1;
					end
					state_q <= ret2_q;
				end
				ST_M1: begin
					if (found_q) begin
						code_q  <= CODE_HIT_T1;
						hits_q  <= hits_q + 1'b1;
						at_q    <= fat_q;
						ptr_q   <= fat_q + 1'b1;
						vld_s1  <= 1'b0;
						ret_q   <= ST_M1B;
						state_q <= ST_RM;
					end else begin
						lst_q   <= LST_T2;
						ptr_q   <= '0;
						ret_q   <= ST_M2;
						state_q <= ST_FIND;
					end
				end
				ST_M1B: begin
					lst_q   <= LST_T2;
					val_q   <= x_q;
					ret_q   <= ST_DONE;
					state_q <= ST_AP;
				end
				ST_M2: begin
					if (found_q) begin
						code_q  <= CODE_HIT_T2;
						hits_q  <= hits_q + 1'b1;
						at_q    <= fat_q;
						ptr_q   <= fat_q + 1'b1;
						vld_s1  <= 1'b0;
						ret_q   <= ST_M1B;
						state_q <= ST_RM;
					end else begin
						lst_q   <= LST_B1;
						ptr_q   <= '0;
						ret_q   <= ST_M3;
						state_q <= ST_FIND;
					end
				end
				ST_M3: begin
					if (found_q) begin
						code_q   <= CODE_GHOST_B1;
						misses_q <= misses_q + 1'b1;
						state_q  <= ST_DIVS;
					end else begin
						lst_q   <= LST_B2;
						ptr_q   <= '0;
						ret_q   <= ST_M4;
						state_q <= ST_FIND;
					end
				end
				ST_M4: begin
					misses_q <= misses_q + 1'b1;
					if (found_q) begin
						code_q  <= CODE_GHOST_B2;
						state_q <= ST_DIVS;
					end else begin
						code_q  <= CODE_MISS;
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					at_q   <= '0;
					ptr_q  <= LW'(1);
					vld_s1 <= 1'b0;
					if (l1 == {1'b0, cap_q}) begin
						if (len_q[LST_T1] < cap_q) begin
							lst_q   <= LST_B1;
							ret_q   <= ST_REPL;
							state_q <= ST_RM;
						end else begin
							lst_q   <= LST_T1;
							ret_q   <= ST_POST;
							state_q <= ST_RM;
						end
					end else if (l1 < {1'b0, cap_q} && all_len >= (LW+2)'(cap_q)) begin
						if (all_len == ((LW+2)'(cap_q) << 1)) begin
							lst_q   <= LST_B2;
							ret_q   <= ST_REPL;
							state_q <= ST_RM;
						end else begin
							state_q <= ST_REPL;
						end
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						if (code_q == CODE_GHOST_B1) begin
							bal_q <= (bal_sum > {1'b0, lim_fx}) ? lim_fx : bal_sum[PW-1:0];
						end else begin
							bal_q <= (delta > bal_q) ? '0 : bal_q - delta;
						end
						state_q <= ST_REPL;
					end
				end
				ST_REPL: begin
					lst_q   <= LST_B2;
					ptr_q   <= '0;
					vld_s1  <= 1'b0;
					ret_q   <= ST_RP1;
					state_q <= ST_FIND;
				end
				ST_RP1: begin
					ptr_q <= '0;
					if (len_q[LST_T1] != '0 &&
					    (t1_fx > bal_q || (found_q && t1_fx == bal_q))) begin
						lst_q   <= LST_T1;
						state_q <= ST_HD0;
					end else if (len_q[LST_T2] != '0) begin
						lst_q   <= LST_T2;
						state_q <= ST_HD0;
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					ptr_q  <= '0;
					vld_s1 <= 1'b0;
					case (code_q)
						CODE_GHOST_B1: begin
							lst_q   <= LST_B1;
							ret_q   <= ST_PM;
							state_q <= ST_FIND;
						end
						CODE_GHOST_B2: begin
							lst_q   <= LST_B2;
							ret_q   <= ST_PM;
							state_q <= ST_FIND;
						end
						default: begin
							lst_q   <= LST_T1;
							val_q   <= x_q;
							ret_q   <= ST_DONE;
							state_q <= ST_AP;
						end
					endcase
				end
				ST_PM: begin
					if (found_q) begin
						at_q    <= fat_q;
						ptr_q   <= fat_q + 1'b1;
						vld_s1  <= 1'b0;
						ret_q   <= ST_PA;
						state_q <= ST_RM;
					end else begin
						state_q <= ST_PA;
					end
				end
				ST_PA: begin
					lst_q   <= LST_T2;
					val_q   <= x_q;
					ret_q   <= ST_DONE;
					state_q <= ST_AP;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= {code_q, (code_q == CODE_HIT_T1 || code_q == CODE_HIT_T2)};
						m_tdata_q  <= {3'b000, misses_q, hits_q, BAL_W'(bal_q)};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

### hw/rtl/arcpr_chk.sv
// ----------------------------------------------------------------------------
// arcpr_chk
// port level checks of the arc page replacement block
// ----------------------------------------------------------------------------
`default_nettype none

module arcpr_chk
	import arcpr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [87:0] m_tdata,
	input wire logic [3:0]  m_tuser
);

	// output holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// hit flag agrees with the case code
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == CODE_HIT_T1 ||
		                             m_tuser[3:1] == CODE_HIT_T2)))
		else $error("hit flag mismatch");

	// case code within range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[3:1] <= CODE_MISS))
		else $error("bad case code");

	// the sequencer is free for a new access once a result is loaded for output
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("input not ready after result");

endmodule

bind arc_page_replacement arcpr_chk u_arcpr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
